/* hdl/bldc_seq_pkg.sv */
// ----------------------------------------------------------------------------
// bldc_seq_pkg
// Shared types, constants and phase tables for the six-step ramp sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_seq_pkg;

  localparam int PWM_PERIOD_DEF  = 4200;
  localparam int STEPS_PER_CYCLE = 6;

  localparam int DELAY_W    = 8;
  localparam int TIME_W     = 16;
  localparam int DUTY_W     = 13;
  localparam int STEP_W     = 3;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = DELAY_W + TIME_W;
  // quotient never exceeds the delay span, so only DELAY_W quotient bits
  localparam int DIV_STEPS  = DELAY_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CODE_W-1:0] CMD_STOP = 8'd68;
  localparam logic [CODE_W-1:0] CMD_HALF = 8'd69;
  localparam logic [CODE_W-1:0] CMD_FULL = 8'd70;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HALF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL   = 3'd5;

  localparam logic [DELAY_W-1:0] START_DELAY_RST = 8'd8;
  localparam logic [DELAY_W-1:0] END_DELAY_RST   = 8'd2;
  localparam logic [TIME_W-1:0]  RAMP_TIME_RST   = 16'd5000;
  localparam logic [TIME_W-1:0]  RUN_TIME_RST    = 16'd6000;
  localparam logic [DUTY_W-1:0]  DUTY_HALF_RST   = 13'd420;
  localparam logic [DUTY_W-1:0]  DUTY_FULL_RST   = 13'd600;

  typedef enum logic [1:0] {
    MS_STOPPED = 2'd0,
    MS_RUNNING = 2'd1,
    MS_FAULT   = 2'd2
  } motor_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FINISH
  } seq_state_e;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic count;     // advance run and step timers
    logic mul;       // form ramp product, load divider
    logic div_step;  // one restoring divide step
    logic commit;    // apply the item's effect, load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_run;  // captured item is a tick and motor is running
  } dp_status_t;

  // phase driven with duty for a step
  function automatic logic [1:0] hi_phase(input logic [STEP_W-1:0] step);
    logic [1:0] p;
    unique case (step)
      3'd0, 3'd1: p = 2'd0;
      3'd2, 3'd3: p = 2'd1;
      3'd4, 3'd5: p = 2'd2;
      default:    p = 2'd0;
    endcase
    return p;
  endfunction

  // phase held at zero for a step
  function automatic logic [1:0] lo_phase(input logic [STEP_W-1:0] step);
    logic [1:0] p;
    unique case (step)
      3'd0:       p = 2'd1;
      3'd1, 3'd2: p = 2'd2;
      3'd3, 3'd4: p = 2'd0;
      3'd5:       p = 2'd1;
      default:    p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/bldc_seq_ctrl.sv */
// ----------------------------------------------------------------------------
// bldc_seq_ctrl
// Sequencing state machine: accepts an item, walks the ramp computation and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_seq_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  input  bldc_seq_pkg::dp_status_t status_i,
  output bldc_seq_pkg::ctrl_cmd_t  cmd_o
);
  import bldc_seq_pkg::*;

  seq_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.count = status_i.tick_run;
        state_d     = status_i.tick_run ? S_MUL : S_FINISH;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hdl/bldc_seq_dp.sv */
// ----------------------------------------------------------------------------
// bldc_seq_dp
// Datapath: configuration registers, motor state, ramp interval product and
// restoring divider, commutation pattern update.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_seq_dp #(
  parameter int PWM_PERIOD = bldc_seq_pkg::PWM_PERIOD_DEF
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        cfg_valid_i,
  input  wire  [bldc_seq_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [bldc_seq_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  bldc_seq_pkg::ctrl_cmd_t                    cmd_i,
  output bldc_seq_pkg::dp_status_t                   status_o,
  input  wire                                        action_i,
  input  wire  [bldc_seq_pkg::CODE_W-1:0]            command_code_i,
  input  wire                                        driver_fault_i,
  input  wire                                        overtemp_warning_i,
  output logic [2:0]                                 phase_on_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]            compare_a_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]            compare_b_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]            compare_c_o,
  output logic                                       gate_on_o,
  output logic [1:0]                                 motor_status_o,
  output logic                                       stepped_o
);
  import bldc_seq_pkg::*;

  // configuration
  logic [DELAY_W-1:0] start_q, end_q;
  logic [TIME_W-1:0]  ramp_q, run_q;
  logic [DUTY_W-1:0]  duty_half_q, duty_full_q;

  // captured item
  logic              action_q;
  logic [CODE_W-1:0] code_q;
  logic              fault_q;

  // motor state
  logic                running_q, running_d;
  motor_status_e       status_q, status_d;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [TIME_W-1:0]   since_q, since_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic [DUTY_W-1:0]   cmp_q [3];
  logic [DUTY_W-1:0]   cmp_d [3];
  logic [2:0]          phen_q, phen_d;
  logic                gate_q, gate_d;
  logic                stepped_q, stepped_d;

  // ramp arithmetic
  logic [DELAY_W-1:0] end_clamp, span, delay;
  logic [TIME_W-1:0]  t_clamp;
  logic [PROD_W-1:0]  prod;
  logic [TIME_W-1:0]  rem_q;
  logic [DELAY_W-1:0] numlo_q, quo_q;
  logic [TIME_W:0]    trial, trial_sub;
  logic               trial_ge;

  logic [DUTY_W-1:0]  duty_sel, duty_sat;
  logic [STEP_W-1:0]  pat_step;
  logic [1:0]         hi, lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_DELAY_RST;
      end_q       <= END_DELAY_RST;
      ramp_q      <= RAMP_TIME_RST;
      run_q       <= RUN_TIME_RST;
      duty_half_q <= DUTY_HALF_RST;
      duty_full_q <= DUTY_FULL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_DELAY: start_q     <= cfg_data_i[DELAY_W-1:0];
        CFG_END_DELAY:   end_q       <= cfg_data_i[DELAY_W-1:0];
        CFG_RAMP_TIME:   ramp_q      <= cfg_data_i;
        CFG_RUN_TIME:    run_q       <= cfg_data_i;
        CFG_DUTY_HALF:   duty_half_q <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_FULL:   duty_full_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      code_q   <= command_code_i;
      fault_q  <= driver_fault_i || overtemp_warning_i;
    end
  end

  assign status_o.tick_run = !action_q && running_q;

  // interval = start - span * min(elapsed, ramp) / ramp, or the clamped end delay when ramp is 0
  assign end_clamp = (end_q < start_q) ? end_q : start_q;
  assign span      = start_q - end_clamp;
  assign t_clamp   = (elapsed_q < ramp_q) ? elapsed_q : ramp_q;
  assign prod      = PROD_W'(span) * PROD_W'(t_clamp);

  // restoring divide, one quotient bit per step; prod < 256 * ramp keeps the
  // upper part below the divisor at load time
  assign trial     = {rem_q, numlo_q[DELAY_W-1]};
  assign trial_sub = trial - {1'b0, ramp_q};
  assign trial_ge  = (trial >= {1'b0, ramp_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q   <= prod[PROD_W-1:DELAY_W];
      numlo_q <= prod[DELAY_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q   <= trial_ge ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
      numlo_q <= {numlo_q[DELAY_W-2:0], 1'b0};
      quo_q   <= {quo_q[DELAY_W-2:0], trial_ge};
    end
  end

  assign delay = (ramp_q == '0) ? end_clamp : (start_q - quo_q);

  assign duty_sel = (code_q == CMD_HALF) ? duty_half_q : duty_full_q;
  assign duty_sat = ({4'b0, duty_sel} > 17'(PWM_PERIOD)) ? DUTY_W'(PWM_PERIOD) : duty_sel;

  assign pat_step = (step_q < STEP_W'(STEPS_PER_CYCLE)) ? step_q : '0;
  assign hi       = hi_phase(pat_step);
  assign lo       = lo_phase(pat_step);

  always_comb begin
    running_d = running_q;
    status_d  = status_q;
    elapsed_d = elapsed_q;
    since_d   = since_q;
    step_d    = step_q;
    duty_d    = duty_q;
    cmp_d     = cmp_q;
    phen_d    = phen_q;
    gate_d    = gate_q;
    stepped_d = stepped_q;

    if (cmd_i.count) begin
      if (elapsed_q != '1) elapsed_d = elapsed_q + 1'b1;
      if (since_q != '1)   since_d   = since_q + 1'b1;
    end

    if (cmd_i.commit) begin
      stepped_d = 1'b0;
      if (action_q) begin
        if (code_q == CMD_STOP) begin
          gate_d    = 1'b0;
          phen_d    = '0;
          running_d = 1'b0;
          status_d  = MS_STOPPED;
        end else if (code_q == CMD_HALF || code_q == CMD_FULL) begin
          duty_d = duty_sat;
          if (!running_q) begin
            gate_d    = 1'b1;
            phen_d    = 3'b111;
            elapsed_d = '0;
            since_d   = '0;
            step_d    = '0;
            running_d = 1'b1;
            status_d  = MS_RUNNING;
          end
        end
      end else if (running_q) begin
        if (elapsed_q >= run_q) begin
          gate_d    = 1'b0;
          phen_d    = '0;
          running_d = 1'b0;
          status_d  = MS_STOPPED;
        end else if (fault_q) begin
          gate_d    = 1'b0;
          phen_d    = '0;
          running_d = 1'b0;
          status_d  = MS_FAULT;
        end else if (since_q >= {{(TIME_W-DELAY_W){1'b0}}, delay}) begin
          since_d    = '0;
          cmp_d[hi]  = duty_q;
          cmp_d[lo]  = '0;
          phen_d     = '0;
          phen_d[hi] = 1'b1;
          phen_d[lo] = 1'b1;
          step_d     = (step_q >= STEP_W'(STEPS_PER_CYCLE - 1)) ? '0 : step_q + 1'b1;
          stepped_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      status_q  <= MS_STOPPED;
      elapsed_q <= '0;
      since_q   <= '0;
      step_q    <= '0;
      duty_q    <= '0;
      cmp_q     <= '{default: '0};
      phen_q    <= '0;
      gate_q    <= 1'b0;
      stepped_q <= 1'b0;
    end else begin
      running_q <= running_d;
      status_q  <= status_d;
      elapsed_q <= elapsed_d;
      since_q   <= since_d;
      step_q    <= step_d;
      duty_q    <= duty_d;
      cmp_q     <= cmp_d;
      phen_q    <= phen_d;
      gate_q    <= gate_d;
      stepped_q <= stepped_d;
    end
  end

  // outputs only move on commit, when the previous result has left; the run and step timers also advance on count
  assign phase_on_o     = phen_q;
  assign compare_a_o    = cmp_q[0];
  assign compare_b_o    = cmp_q[1];
  assign compare_c_o    = cmp_q[2];
  assign gate_on_o      = gate_q;
  assign motor_status_o = status_q;
  assign stepped_o      = stepped_q;

endmodule

`default_nettype wire

/* hdl/six_step_bldc_ramp_sequencer.sv */
// ----------------------------------------------------------------------------
// six_step_bldc_ramp_sequencer
// Open-loop six-step BLDC commutator with a linearly ramped step interval.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o     | action, command_code, pin faults
//  out     | output    | out_valid_o / out_stall_i   | phase enables, compares, gate,
//          |           |                             | motor_status, stepped
//  cfg     | input     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
//  A command item, or a tick while stopped, walks idle, check and finish before the next accept.
//  A tick while running also takes a multiply step and the restoring divider steps that form
//  the ramp interval; finish waits while the previous result is still stalled.
//  A new item is taken while the previous result waits; it commits only once that
//  result has been taken. Reset is asynchronous and loads the default registers.
`default_nettype none

module six_step_bldc_ramp_sequencer #(
  parameter int PWM_PERIOD = bldc_seq_pkg::PWM_PERIOD_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 action_i,
  input  wire  [bldc_seq_pkg::CODE_W-1:0]     command_code_i,
  input  wire                                 driver_fault_i,
  input  wire                                 overtemp_warning_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                phase_a_on_o,
  output logic                                phase_b_on_o,
  output logic                                phase_c_on_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]     compare_a_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]     compare_b_o,
  output logic [bldc_seq_pkg::DUTY_W-1:0]     compare_c_o,
  output logic                                gate_on_o,
  output logic [1:0]                          motor_status_o,
  output logic                                stepped_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [bldc_seq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [bldc_seq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bldc_seq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [2:0] phase_on;

  assign cfg_ready_o = 1'b1;

  bldc_seq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bldc_seq_dp #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .action_i           (action_i),
    .command_code_i     (command_code_i),
    .driver_fault_i     (driver_fault_i),
    .overtemp_warning_i (overtemp_warning_i),
    .phase_on_o         (phase_on),
    .compare_a_o        (compare_a_o),
    .compare_b_o        (compare_b_o),
    .compare_c_o        (compare_c_o),
    .gate_on_o          (gate_on_o),
    .motor_status_o     (motor_status_o),
    .stepped_o          (stepped_o)
  );

  assign phase_a_on_o = phase_on[0];
  assign phase_b_on_o = phase_on[1];
  assign phase_c_on_o = phase_on[2];

endmodule

`default_nettype wire
